// ===== sv/alkef_pkg.sv =====
package alkef_pkg;

    localparam int KEY_COUNT = 11;
    localparam int ADC_BITS  = 12;

    localparam int SAMPLE_W = 12;
    localparam int KEY_W    = $clog2(KEY_COUNT + 1);
    localparam int CNT_W    = 16;
    localparam int DBN_W    = 8;
    localparam int LIM_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int ADC_FULL = 1 << ADC_BITS;
    localparam int ADC_HALF = (ADC_FULL / KEY_COUNT) / 2;
    localparam int PROD_W   = ADC_BITS + KEY_W;

    localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(KEY_COUNT);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

    localparam logic [DBN_W-1:0] DEBOUNCE_RST = 8'd3;
    localparam logic [LIM_W-1:0] LONG_RST     = 16'd80;
    localparam logic [LIM_W-1:0] REPEAT_RST   = 16'd50;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_PRESSED       = 3'd1,
        EV_RELEASED      = 3'd2,
        EV_LONG_PRESSED  = 3'd3,
        EV_LONG_RELEASED = 3'd4,
        EV_REPEAT        = 3'd5
    } event_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } key_req_t;

endpackage

// ===== sv/alkef_if.sv =====
interface alkef_sample_if
    import alkef_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface alkef_event_if
    import alkef_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic [2:0]       event_kind;

    modport source (output valid, output key_index, output event_kind, input ready);
    modport sink   (input valid, input key_index, input event_kind, output ready);
endinterface

// ===== sv/alkef_front.sv =====
module alkef_front
    import alkef_pkg::*;
(
    alkef_sample_if.sink sample_ch,
    input  logic         q_ready,
    output key_req_t     q_push
);

    localparam logic [PROD_W-1:0] KEY_MUL  = PROD_W'(KEY_COUNT);
    localparam logic [PROD_W-1:0] HALF_ADD = PROD_W'(ADC_HALF);

    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] prod;

    // key = (s + half) * KEY_COUNT / 2^ADC_BITS
    assign sum  = PROD_W'(sample_ch.adc_sample[ADC_BITS-1:0]) + HALF_ADD;
    assign prod = sum * KEY_MUL;

    assign q_push.valid    = sample_ch.valid;
    assign q_push.key      = prod[PROD_W-1:ADC_BITS];
    assign sample_ch.ready = q_ready;

endmodule

// ===== sv/alkef_queue.sv =====
module alkef_queue
    import alkef_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  key_req_t push,
    output logic     push_ready,
    output key_req_t head,
    input  logic     pop
);

    logic [KEY_W-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.key   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.key;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

endmodule

// ===== sv/alkef_back.sv =====
module alkef_back
    import alkef_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  key_req_t              head,
    output logic                  pop,
    alkef_event_if.source         event_ch
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [KEY_W-1:0]  held_key_reg;
    logic [KEY_W-1:0]  held_key_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  cnt_tick;
    logic [DBN_W-1:0]  dbn_reg;
    logic [LIM_W-1:0]  long_reg;
    logic [LIM_W-1:0]  rep_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [KEY_W-1:0]  out_key_reg;
    logic [KEY_W-1:0]  ev_key;
    event_t            out_ev_reg;
    event_t            ev;
    logic              key_same;
    logic              key_seen;
    logic              dbn_hit;
    logic              dbn_zero;
    logic              long_hit;
    logic              rep_hit;

    assign pop      = head.valid && (!out_valid_reg || event_ch.ready);
    assign cnt_tick = (cnt_reg != CNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign key_same = (head.key == held_key_reg);
    assign key_seen = (head.key != NO_KEY);
    assign dbn_zero = (dbn_reg == '0);
    assign dbn_hit  = (cnt_tick >= CNT_W'(dbn_reg));
    assign long_hit = (cnt_tick >= long_reg);
    assign rep_hit  = (cnt_tick >= rep_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbn_reg  <= DEBOUNCE_RST;
            long_reg <= LONG_RST;
            rep_reg  <= REPEAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: dbn_reg  <= cfg_data[DBN_W-1:0];
                CFG_LONG:     long_reg <= cfg_data[LIM_W-1:0];
                CFG_REPEAT:   rep_reg  <= cfg_data[LIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (key_seen)
                begin
                    phase_next = dbn_zero ? PH_PRESSED : PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (!key_same)
                begin
                    phase_next = PH_IDLE;
                end
                else if (dbn_hit)
                begin
                    phase_next = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                if (!key_same)
                begin
                    phase_next = PH_IDLE;
                end
                else if (long_hit)
                begin
                    phase_next = PH_LONG;
                end
            end
            PH_LONG:
            begin
                if (!key_same)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // held key, scan counter and event
    always_comb
    begin
        held_key_next = held_key_reg;
        cnt_next      = cnt_tick;
        ev_key        = NO_KEY;
        ev            = EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                cnt_next = cnt_reg;
                if (key_seen)
                begin
                    held_key_next = head.key;
                    cnt_next      = '0;
                    if (dbn_zero)
                    begin
                        ev_key = head.key;
                        ev     = EV_PRESSED;
                    end
                end
            end
            PH_DEBOUNCE:
            begin
                if (!key_same)
                begin
                    held_key_next = NO_KEY;
                end
                else if (dbn_hit)
                begin
                    cnt_next = '0;
                    ev_key   = held_key_reg;
                    ev       = EV_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                if (!key_same)
                begin
                    held_key_next = NO_KEY;
                    ev_key        = held_key_reg;
                    ev            = EV_RELEASED;
                end
                else if (long_hit)
                begin
                    cnt_next = '0;
                    ev_key   = held_key_reg;
                    ev       = EV_LONG_PRESSED;
                end
            end
            PH_LONG:
            begin
                if (!key_same)
                begin
                    held_key_next = NO_KEY;
                    ev_key        = held_key_reg;
                    ev            = EV_LONG_RELEASED;
                end
                else if (rep_hit)
                begin
                    cnt_next = '0;
                    ev_key   = held_key_reg;
                    ev       = EV_REPEAT;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (event_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_key_reg  <= NO_KEY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg    <= phase_next;
                held_key_reg <= held_key_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_key_reg <= ev_key;
            out_ev_reg  <= ev;
        end
    end

    assign event_ch.valid      = out_valid_reg;
    assign event_ch.key_index  = out_key_reg;
    assign event_ch.event_kind = out_ev_reg;

    a_idle_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> held_key_reg == NO_KEY)
        else $error("held key set while idle");

    a_press_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ev_reg == EV_PRESSED |-> phase_reg == PH_PRESSED)
        else $error("press event without pressed phase");

    a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_ev_reg == EV_RELEASED || out_ev_reg == EV_LONG_RELEASED)
        |-> phase_reg == PH_IDLE)
        else $error("release event without return to idle");

endmodule

// ===== sv/adc_ladder_key_event_fsm.sv =====
// channel    | dir | payload                      | handshake
// sample_ch  | in  | adc_sample[11:0]             | valid/ready
// event_ch   | out | key_index[3:0], event_kind   | valid/ready
// cfg        | in  | cfg_index[1:0], cfg_data     | cfg_we, no wait
//
// One request per cycle sustained while event_ch is ready; each sample gives one event.
// Sample path: quantizer into a two-entry queue, phase machine into the
// output register.
// Reset clears the phase machine, queue and output valid; limits return to 3/80/50.
// Output stall backs up the queue, then drops sample_ch.ready.
module adc_ladder_key_event_fsm
    import alkef_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    alkef_sample_if.sink          sample_ch,
    alkef_event_if.source         event_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    key_req_t q_push;
    key_req_t q_head;
    logic     q_ready;
    logic     q_pop;

    alkef_front u_front (
        .sample_ch (sample_ch),
        .q_ready   (q_ready),
        .q_push    (q_push)
    );

    alkef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .head       (q_head),
        .pop        (q_pop)
    );

    alkef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (q_head),
        .pop       (q_pop),
        .event_ch  (event_ch)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import alkef_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 190;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        event_t           kind;
    } key_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alkef_sample_if sample_ch();
    alkef_event_if  event_ch();

    adc_ladder_key_event_fsm uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .event_ch  (event_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ladder position: round to the nearest of KEY_COUNT steps
    function automatic logic [KEY_W-1:0] key_of(input logic [SAMPLE_W-1:0] s);
        logic [31:0] scaled;
        scaled = ((32'(s) & 32'(ADC_FULL - 1)) + 32'(ADC_HALF)) * 32'(KEY_COUNT);
        return KEY_W'(scaled >> ADC_BITS);
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_for(input logic [KEY_W-1:0] k);
        logic [SAMPLE_W-1:0] s;
        do
            s = SAMPLE_W'($urandom_range(0, ADC_FULL - 1));
        while (key_of(s) != k);
        return s;
    endfunction

    class key_event_scoreboard;
        phase_t           phase;
        logic [KEY_W-1:0] held_key;
        logic [CNT_W-1:0] scans;
        logic [DBN_W-1:0] debounce_lim;
        logic [LIM_W-1:0] long_lim;
        logic [LIM_W-1:0] repeat_lim;
        key_event_t       expected_events[$];
        int               errors;

        function new();
            phase        = PH_IDLE;
            held_key     = NO_KEY;
            scans        = '0;
            debounce_lim = DEBOUNCE_RST;
            long_lim     = LONG_RST;
            repeat_lim   = REPEAT_RST;
            errors       = 0;
        endfunction

        function void set_limits(logic [DBN_W-1:0] dbn, logic [LIM_W-1:0] lng,
                                 logic [LIM_W-1:0] rep);
            debounce_lim = dbn;
            long_lim     = lng;
            repeat_lim   = rep;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [KEY_W-1:0] k;
            key_event_t       ev;
            k       = key_of(s);
            ev.key  = NO_KEY;
            ev.kind = EV_NONE;
            if (phase != PH_IDLE && scans != CNT_MAX)
                scans++;
            case (phase)
                PH_IDLE:
                begin
                    if (k != NO_KEY)
                    begin
                        held_key = k;
                        scans    = '0;
                        phase    = PH_DEBOUNCE;
                        if (scans >= CNT_W'(debounce_lim))
                        begin
                            phase   = PH_PRESSED;
                            ev.key  = held_key;
                            ev.kind = EV_PRESSED;
                        end
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (k != held_key)
                    begin
                        held_key = NO_KEY;
                        phase    = PH_IDLE;
                    end
                    else if (scans >= CNT_W'(debounce_lim))
                    begin
                        scans   = '0;
                        phase   = PH_PRESSED;
                        ev.key  = held_key;
                        ev.kind = EV_PRESSED;
                    end
                end
                PH_PRESSED:
                begin
                    if (k != held_key)
                    begin
                        ev.key   = held_key;
                        ev.kind  = EV_RELEASED;
                        held_key = NO_KEY;
                        phase    = PH_IDLE;
                    end
                    else if (scans >= long_lim)
                    begin
                        scans   = '0;
                        phase   = PH_LONG;
                        ev.key  = held_key;
                        ev.kind = EV_LONG_PRESSED;
                    end
                end
                default:
                begin
                    if (k != held_key)
                    begin
                        ev.key   = held_key;
                        ev.kind  = EV_LONG_RELEASED;
                        held_key = NO_KEY;
                        phase    = PH_IDLE;
                    end
                    else if (scans >= repeat_lim)
                    begin
                        scans   = '0;
                        ev.key  = held_key;
                        ev.kind = EV_REPEAT;
                    end
                end
            endcase
            expected_events.push_back(ev);
        endfunction

        function void check_event(logic [KEY_W-1:0] key, logic [2:0] kind);
            key_event_t ev;
            if (expected_events.size() == 0)
            begin
                $error("unexpected event: key_index %0d, event_kind %0d", key, kind);
                errors++;
                return;
            end
            ev = expected_events.pop_front();
            if (key != ev.key)
            begin
                $error("key_index: expected %0d, got %0d", ev.key, key);
                errors++;
            end
            if (kind != ev.kind)
            begin
                $error("event_kind: expected %0d, got %0d", ev.kind, kind);
                errors++;
            end
        endfunction
    endclass

    key_event_scoreboard sb = new();

    int burst_left;
    int stalled_cycles;
    int samples_sent;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // called at a falling edge, returns at a falling edge
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        if (burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(s);
        samples_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic hold_key(input logic [KEY_W-1:0] k, input int n);
        repeat (n) push_sample(sample_for(k));
    endtask

    task automatic drain_events();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [DBN_W-1:0] dbn, input logic [LIM_W-1:0] lng,
                              input logic [LIM_W-1:0] rep);
        drain_events();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= {8'($urandom_range(0, 255)), dbn};
        @(negedge clk);
        cfg_index <= CFG_LONG;
        cfg_data  <= lng;
        @(negedge clk);
        cfg_index <= CFG_REPEAT;
        cfg_data  <= rep;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_limits(dbn, lng, rep);
        @(negedge clk);
    endtask

    task automatic run_episode();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] k2;
        int               pick;
        int               span;
        int               n;
        pick = $urandom_range(0, 19);
        k    = KEY_W'($urandom_range(0, KEY_COUNT - 1));
        k2   = KEY_W'((int'(k) + 1 + $urandom_range(0, KEY_COUNT - 2)) % KEY_COUNT);
        span = int'(sb.debounce_lim) + int'(sb.long_lim) + 3 * int'(sb.repeat_lim) + 6;
        if (span > 400)
            span = 400;
        if (pick < 14)
        begin
            n = (pick < 9) ? int'(sb.debounce_lim) + $urandom_range(1, span)
                           : $urandom_range(1, span);
            hold_key(k, n);
            if (pick % 3 == 0)
                hold_key(k2, $urandom_range(1, 3));
            else
                hold_key(NO_KEY, $urandom_range(1, 4));
        end
        else if (pick < 17)
        begin
            // bounce to another key before or just as the debounce time is up
            hold_key(k, $urandom_range(1, int'(sb.debounce_lim) + 1));
            hold_key(k2, $urandom_range(1, 2));
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                push_sample(SAMPLE_W'($urandom()));
        end
        if ($urandom_range(0, 24) == 0)
            drain_events();
    endtask

    initial
    begin
        int unsigned ready_tick;
        int          ready_mode;
        ready_tick     = 0;
        ready_mode     = 0;
        event_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            ready_tick++;
            if (ready_tick % 83 == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0:       event_ch.ready <= 1'b1;
                1:       event_ch.ready <= (ready_tick % 4 != 0);
                2:       event_ch.ready <= ($urandom_range(0, 1) == 1);
                default: event_ch.ready <= ((ready_tick % 32) >= 10);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && event_ch.valid && event_ch.ready)
            sb.check_event(event_ch.key_index, event_ch.event_kind);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int base;
        int p;
        rst_n                = 1'b0;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_DEBOUNCE;
        cfg_data             = '0;
        burst_left           = 0;
        stalled_cycles       = 0;
        samples_sent         = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset limits 3/80/50
        repeat (5) push_sample(12'd0);
        push_sample(12'd4095);
        push_sample(12'd186);
        push_sample(12'd186);
        push_sample(12'd187);
        push_sample(12'd187);
        push_sample(12'd3910);
        repeat (4) push_sample(12'd3909);
        push_sample(12'd100);
        push_sample(12'd100);
        push_sample(12'd3910);
        push_sample(12'd3910);

        base = samples_sent;
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:       ;
                1:       set_limits(8'd0, 16'd0, 16'd0);
                2:       set_limits(8'd255, 16'd12, 16'd4);
                3:       set_limits(8'd1, 16'd1, 16'd1);
                default: set_limits(DBN_W'($urandom_range(0, 6)), LIM_W'($urandom_range(0, 40)),
                                    LIM_W'($urandom_range(0, 15)));
            endcase
            do
                run_episode();
            while (samples_sent < base + (p + 1) * PHASE_ITEMS);
        end

        drain_events();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
